// ===== src/mts_pkg.sv =====
package mts_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int OUT_BITS    = 16;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    typedef enum logic [2:0] {
        PH_BETWEEN     = 3'd0,
        PH_AFTER_LT    = 3'd1,
        PH_AFTER_SLASH = 3'd2,
        PH_IN_TAG      = 3'd3,
        PH_CONTENT     = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_OPEN    = 3'd0,
        KIND_CLOSE   = 3'd1,
        KIND_SELF    = 3'd2,
        KIND_CONTENT = 3'd3,
        KIND_END     = 3'd4
    } kind_t;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef struct packed {
        kind_t               kind;
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] length;
        logic [15:0]         line;
        logic                unterm;
        logic                last;
    } result_t;

    // one result request from the scanner to the output queue
    typedef struct packed {
        logic    valid;
        result_t res;
    } res_req_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic offset_t span(input offset_t from, input offset_t upto);
        return (upto >= from) ? offset_t'(upto - from) : '0;
    endfunction

    function automatic logic [OUT_BITS-1:0] sat_out(input offset_t v);
        logic [OFFSET_BITS+OUT_BITS-1:0] wide;
        wide = {{OUT_BITS{1'b0}}, v};
        if (wide > (OFFSET_BITS+OUT_BITS)'({OUT_BITS{1'b1}}))
            return {OUT_BITS{1'b1}};
        else
            return wide[OUT_BITS-1:0];
    endfunction

endpackage

// ===== src/markup_token_scanner.sv =====
// path: a request accepted into the input register has its result pushed into the
//   output queue register, from which m_axis shows it; a full queue stalls the push
// throughput: one byte per cycle while the output queue has room; an end-of-input
//   request that cuts off a token is held until the cut-off token and then the end
//   token have left; results leave the scanner one per cycle into a two-entry output queue
// reset: rst_n clears the scanner to between tokens, offset 0, line 1, queue empty
module markup_token_scanner
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // start_offset, token_length, line_number
    output logic [3:0]  m_axis_tuser,   // token_kind, unterminated
    output logic        m_axis_tlast    // last_of_run
);

    mts_pkg::res_req_t push;
    mts_pkg::result_t  out_res;
    logic              out_full;

    mts_scan_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (s_axis_tuser),
        .in_byte  (s_axis_tdata),
        .out_full (out_full),
        .push     (push)
    );

    mts_out_fifo u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (out_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.line, out_res.length, out_res.start};
    assign m_axis_tuser = {out_res.unterm, out_res.kind};
    assign m_axis_tlast = out_res.last;

endmodule

// ===== src/mts_out_fifo.sv =====
module mts_out_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  mts_pkg::res_req_t   push,
    output logic                full,
    output logic                out_valid,
    input  logic                out_ready,
    output mts_pkg::result_t    out_res
);

    mts_pkg::result_t slot0_reg;
    mts_pkg::result_t slot1_reg;
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_res   = head_reg ? slot1_reg : slot0_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = ~head_reg;
        end
        if (push.valid)
        begin
            tail_next = ~tail_reg;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push.valid && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid && !tail_reg)
        begin
            slot0_reg <= push.res;
        end
        if (push.valid && tail_reg)
        begin
            slot1_reg <= push.res;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (count_reg != 2'd2))
        else $error("result pushed into full queue");

endmodule

// ===== src/mts_scan_core.sv =====
module mts_scan_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_mode,
    input  logic [7:0]         in_byte,
    input  logic               out_full,
    output mts_pkg::res_req_t  push
);

    // input register
    logic       in_valid_reg;
    logic       in_mode_reg;
    logic [7:0] in_byte_reg;

    // scanner state
    mts_pkg::phase_t  phase_reg, phase_next;
    mts_pkg::offset_t byte_offset_reg, byte_offset_next;
    mts_pkg::offset_t token_start_reg, token_start_next;
    logic [7:0]       prev_byte_reg, prev_byte_next;
    logic [15:0]      line_count_reg, line_count_next;
    logic             close_tag_reg, close_tag_next;
    logic             ignore_tag_reg, ignore_tag_next;
    logic             end_half_reg, end_half_next;

    logic             step;
    logic             consume;
    logic             ws;
    mts_pkg::offset_t tag_end;
    mts_pkg::kind_t   tag_kind;
    mts_pkg::kind_t   open_kind;
    logic             byte_res_valid;
    mts_pkg::result_t byte_res;
    logic             cut_valid;
    mts_pkg::result_t cut_res;
    mts_pkg::result_t end_res;

    assign step     = in_valid_reg && !out_full;
    assign in_ready = !in_valid_reg || consume;
    assign ws       = mts_pkg::is_space(in_byte_reg);

    assign open_kind = close_tag_reg ? mts_pkg::KIND_CLOSE : mts_pkg::KIND_OPEN;

    // result of a data byte: '>' closing a tag or '<' ending content
    always_comb
    begin
        tag_kind = open_kind;
        tag_end  = byte_offset_reg;
        if (!close_tag_reg && prev_byte_reg == mts_pkg::CH_SLASH)
        begin
            tag_kind = mts_pkg::KIND_SELF;
            tag_end  = (byte_offset_reg != '0) ? mts_pkg::offset_t'(byte_offset_reg - 1'b1)
                                                : '0;
        end

        byte_res        = '0;
        byte_res.line   = line_count_reg;
        byte_res.last   = 1'b1;
        byte_res.start  = mts_pkg::sat_out(token_start_reg);
        byte_res_valid  = 1'b0;
        if (phase_reg == mts_pkg::PH_IN_TAG && in_byte_reg == mts_pkg::CH_GT)
        begin
            byte_res.kind   = tag_kind;
            byte_res.length = mts_pkg::sat_out(mts_pkg::span(token_start_reg, tag_end));
            byte_res_valid  = !(tag_kind == mts_pkg::KIND_OPEN && ignore_tag_reg);
        end
        else if (phase_reg == mts_pkg::PH_CONTENT && in_byte_reg == mts_pkg::CH_LT)
        begin
            byte_res.kind   = mts_pkg::KIND_CONTENT;
            byte_res.length = mts_pkg::sat_out(mts_pkg::span(token_start_reg,
                                                             byte_offset_reg));
            byte_res_valid  = 1'b1;
        end
    end

    // token cut off by end of input, followed by the end token
    always_comb
    begin
        cut_res       = '0;
        cut_res.line  = line_count_reg;
        cut_valid     = 1'b0;
        case (phase_reg)
            mts_pkg::PH_CONTENT:
            begin
                cut_valid      = 1'b1;
                cut_res.kind   = mts_pkg::KIND_CONTENT;
                cut_res.start  = mts_pkg::sat_out(token_start_reg);
                cut_res.length = mts_pkg::sat_out(mts_pkg::span(token_start_reg,
                                                                byte_offset_reg));
            end
            mts_pkg::PH_AFTER_LT, mts_pkg::PH_AFTER_SLASH:
            begin
                cut_valid      = 1'b1;
                cut_res.kind   = open_kind;
                cut_res.start  = mts_pkg::sat_out(byte_offset_reg);
                cut_res.unterm = 1'b1;
            end
            mts_pkg::PH_IN_TAG:
            begin
                cut_valid      = close_tag_reg || !ignore_tag_reg;
                cut_res.kind   = open_kind;
                cut_res.start  = mts_pkg::sat_out(token_start_reg);
                cut_res.length = mts_pkg::sat_out(mts_pkg::span(token_start_reg,
                                                                byte_offset_reg));
                cut_res.unterm = 1'b1;
            end
            default:
            begin
                cut_valid = 1'b0;
            end
        endcase

        end_res        = '0;
        end_res.kind   = mts_pkg::KIND_END;
        end_res.start  = mts_pkg::sat_out((byte_offset_reg != '0)
                             ? mts_pkg::offset_t'(byte_offset_reg - 1'b1) : '0);
        end_res.line   = line_count_reg;
        end_res.last   = 1'b1;
    end

    // outputs: which result goes out and whether the input item is done
    always_comb
    begin
        push          = '0;
        consume       = 1'b0;
        end_half_next = end_half_reg;
        if (step)
        begin
            if (in_mode_reg == mts_pkg::MODE_END)
            begin
                if (cut_valid && !end_half_reg)
                begin
                    push.valid    = 1'b1;
                    push.res      = cut_res;
                    end_half_next = 1'b1;
                end
                else
                begin
                    push.valid    = 1'b1;
                    push.res      = end_res;
                    consume       = 1'b1;
                    end_half_next = 1'b0;
                end
            end
            else
            begin
                push.valid = byte_res_valid;
                push.res   = byte_res;
                consume    = 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        byte_offset_next = byte_offset_reg;
        token_start_next = token_start_reg;
        prev_byte_next   = prev_byte_reg;
        line_count_next  = line_count_reg;
        close_tag_next   = close_tag_reg;
        ignore_tag_next  = ignore_tag_reg;
        if (step && in_mode_reg == mts_pkg::MODE_END && consume)
        begin
            phase_next       = mts_pkg::PH_BETWEEN;
            byte_offset_next = '0;
            token_start_next = '0;
            prev_byte_next   = 8'd0;
            line_count_next  = 16'd1;
            close_tag_next   = 1'b0;
            ignore_tag_next  = 1'b0;
        end
        else if (step && in_mode_reg == mts_pkg::MODE_DATA)
        begin
            if (in_byte_reg == mts_pkg::CH_LF && line_count_reg != 16'hFFFF)
            begin
                line_count_next = line_count_reg + 16'd1;
            end
            unique case (phase_reg)
                mts_pkg::PH_BETWEEN:
                begin
                    if (!ws)
                    begin
                        if (in_byte_reg == mts_pkg::CH_LT)
                        begin
                            phase_next      = mts_pkg::PH_AFTER_LT;
                            close_tag_next  = 1'b0;
                            ignore_tag_next = 1'b0;
                        end
                        else
                        begin
                            token_start_next = byte_offset_reg;
                            phase_next       = mts_pkg::PH_CONTENT;
                        end
                    end
                end
                mts_pkg::PH_AFTER_LT:
                begin
                    if (!ws)
                    begin
                        if (in_byte_reg == mts_pkg::CH_SLASH)
                        begin
                            close_tag_next = 1'b1;
                            phase_next     = mts_pkg::PH_AFTER_SLASH;
                        end
                        else
                        begin
                            token_start_next = byte_offset_reg;
                            ignore_tag_next  = (in_byte_reg == mts_pkg::CH_QUEST) ||
                                               (in_byte_reg == mts_pkg::CH_BANG);
                            phase_next       = mts_pkg::PH_IN_TAG;
                        end
                    end
                end
                mts_pkg::PH_AFTER_SLASH:
                begin
                    if (!ws)
                    begin
                        token_start_next = byte_offset_reg;
                        phase_next       = mts_pkg::PH_IN_TAG;
                    end
                end
                mts_pkg::PH_IN_TAG:
                begin
                    if (in_byte_reg == mts_pkg::CH_GT)
                    begin
                        phase_next = mts_pkg::PH_BETWEEN;
                    end
                end
                mts_pkg::PH_CONTENT:
                begin
                    if (in_byte_reg == mts_pkg::CH_LT)
                    begin
                        phase_next      = mts_pkg::PH_AFTER_LT;
                        close_tag_next  = 1'b0;
                        ignore_tag_next = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = mts_pkg::PH_BETWEEN;
                end
            endcase
            prev_byte_next = in_byte_reg;
            if (byte_offset_reg != '1)
            begin
                byte_offset_next = byte_offset_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            phase_reg       <= mts_pkg::PH_BETWEEN;
            byte_offset_reg <= '0;
            token_start_reg <= '0;
            prev_byte_reg   <= 8'd0;
            line_count_reg  <= 16'd1;
            close_tag_reg   <= 1'b0;
            ignore_tag_reg  <= 1'b0;
            end_half_reg    <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_valid_reg <= 1'b0;
            end
            phase_reg       <= phase_next;
            byte_offset_reg <= byte_offset_next;
            token_start_reg <= token_start_next;
            prev_byte_reg   <= prev_byte_next;
            line_count_reg  <= line_count_next;
            close_tag_reg   <= close_tag_next;
            ignore_tag_reg  <= ignore_tag_next;
            end_half_reg    <= end_half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_mode_reg <= in_mode;
            in_byte_reg <= in_byte;
        end
    end

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.res.kind == mts_pkg::KIND_END)
            |=> (phase_reg == mts_pkg::PH_BETWEEN && byte_offset_reg == '0))
        else $error("end token did not return scanner to reset state");

    a_end_half_holds: assert property (@(posedge clk) disable iff (!rst_n)
        end_half_reg |-> (in_valid_reg && in_mode_reg == mts_pkg::MODE_END))
        else $error("pending end token without end request held");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_count_reg != 16'd0)
        else $error("line count wrapped to zero");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int MAX_REPORTS   = 10;

    typedef logic [mts_pkg::OFFSET_BITS-1:0] count_t;

    typedef struct {
        mts_pkg::kind_t kind;
        logic [15:0]    start;
        logic [15:0]    length;
        logic [15:0]    line;
        logic           unterm;
        logic           last;
    } token_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // start_offset, token_length, line_number
    logic [3:0]  m_axis_tuser;   // token_kind, unterminated
    logic        m_axis_tlast;   // last_of_run

    // scanner state as predicted
    mts_pkg::phase_t scan_phase;
    count_t          byte_count;
    count_t          tok_start;
    logic [7:0]      prev_byte;
    logic [15:0]     line_count;
    logic            in_close;
    logic            in_ignored;

    token_t      pending_tokens[$];
    int          bad_tokens;
    int          items_sent;
    int          cycle_count;
    int          burst_left;
    int          gap_left;
    int unsigned stall_style;
    int          stall_left;

    markup_token_scanner i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [15:0] clip16(input count_t v);
        longint unsigned w;
        w = longint'(v);
        return (w > 64'd65535) ? 16'hFFFF : 16'(w);
    endfunction

    function automatic count_t gap_between(input count_t from, input count_t upto);
        return (upto >= from) ? count_t'(upto - from) : '0;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == mts_pkg::CH_SPACE) || (c == mts_pkg::CH_TAB) ||
               (c == mts_pkg::CH_CR) || (c == mts_pkg::CH_LF);
    endfunction

    function automatic token_t make_token(input mts_pkg::kind_t k, input count_t at,
                                          input count_t len, input logic cut);
        token_t t;
        t.kind   = k;
        t.start  = clip16(at);
        t.length = clip16(len);
        t.line   = line_count;
        t.unterm = cut;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic void clear_scan_state();
        scan_phase = mts_pkg::PH_BETWEEN;
        byte_count = '0;
        tok_start  = '0;
        prev_byte  = 8'h00;
        line_count = 16'd1;
        in_close   = 1'b0;
        in_ignored = 1'b0;
    endfunction

    task automatic predict_tokens(input logic mode, input logic [7:0] c);
        token_t         batch[$];
        count_t         pos;
        count_t         stop;
        mts_pkg::kind_t k;
        logic           ws;
        if (mode == mts_pkg::MODE_END)
        begin
            k = in_close ? mts_pkg::KIND_CLOSE : mts_pkg::KIND_OPEN;
            case (scan_phase)
                mts_pkg::PH_CONTENT:
                    batch.push_back(make_token(mts_pkg::KIND_CONTENT, tok_start,
                                               gap_between(tok_start, byte_count), 1'b0));
                mts_pkg::PH_AFTER_LT, mts_pkg::PH_AFTER_SLASH:
                    batch.push_back(make_token(k, byte_count, '0, 1'b1));
                mts_pkg::PH_IN_TAG:
                    // a cut-off ignored open tag still yields nothing
                    if (in_close || !in_ignored)
                        batch.push_back(make_token(k, tok_start,
                                                   gap_between(tok_start, byte_count), 1'b1));
                default:
                    ;
            endcase
            batch.push_back(make_token(mts_pkg::KIND_END,
                                       (byte_count != '0) ? byte_count - 1'b1 : '0,
                                       '0, 1'b0));
            clear_scan_state();
        end
        else
        begin
            pos = byte_count;
            ws  = is_blank(c);
            if (c == mts_pkg::CH_LF && line_count != 16'hFFFF)
                line_count++;
            case (scan_phase)
                mts_pkg::PH_BETWEEN:
                    if (!ws)
                    begin
                        if (c == mts_pkg::CH_LT)
                        begin
                            scan_phase = mts_pkg::PH_AFTER_LT;
                            in_close   = 1'b0;
                            in_ignored = 1'b0;
                        end
                        else
                        begin
                            tok_start  = pos;
                            scan_phase = mts_pkg::PH_CONTENT;
                        end
                    end
                mts_pkg::PH_AFTER_LT:
                    if (!ws)
                    begin
                        if (c == mts_pkg::CH_SLASH)
                        begin
                            in_close   = 1'b1;
                            scan_phase = mts_pkg::PH_AFTER_SLASH;
                        end
                        else
                        begin
                            tok_start  = pos;
                            in_ignored = (c == mts_pkg::CH_QUEST) || (c == mts_pkg::CH_BANG);
                            scan_phase = mts_pkg::PH_IN_TAG;
                        end
                    end
                mts_pkg::PH_AFTER_SLASH:
                    if (!ws)
                    begin
                        tok_start  = pos;
                        scan_phase = mts_pkg::PH_IN_TAG;
                    end
                mts_pkg::PH_IN_TAG:
                    if (c == mts_pkg::CH_GT)
                    begin
                        k    = in_close ? mts_pkg::KIND_CLOSE : mts_pkg::KIND_OPEN;
                        stop = pos;
                        if (!in_close && prev_byte == mts_pkg::CH_SLASH)
                        begin
                            k    = mts_pkg::KIND_SELF;
                            stop = (stop != '0) ? stop - 1'b1 : '0;
                        end
                        if (!(k == mts_pkg::KIND_OPEN && in_ignored))
                            batch.push_back(make_token(k, tok_start,
                                                       gap_between(tok_start, stop), 1'b0));
                        scan_phase = mts_pkg::PH_BETWEEN;
                    end
                mts_pkg::PH_CONTENT:
                    if (c == mts_pkg::CH_LT)
                    begin
                        batch.push_back(make_token(mts_pkg::KIND_CONTENT, tok_start,
                                                   gap_between(tok_start, pos), 1'b0));
                        scan_phase = mts_pkg::PH_AFTER_LT;
                        in_close   = 1'b0;
                        in_ignored = 1'b0;
                    end
                default:
                    scan_phase = mts_pkg::PH_BETWEEN;
            endcase
            prev_byte = c;
            if (byte_count != '1)
                byte_count++;
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            pending_tokens.push_back(batch[i]);
    endtask

    // ---------------------------------------------------------------- result check

    always @(posedge clk)
    begin : check_results
        token_t want;
        logic [2:0] got_kind;
        logic [15:0] got_start;
        logic [15:0] got_length;
        logic [15:0] got_line;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_kind   = m_axis_tuser[2:0];
            got_start  = m_axis_tdata[15:0];
            got_length = m_axis_tdata[31:16];
            got_line   = m_axis_tdata[47:32];
            if (pending_tokens.size() == 0)
            begin
                bad_tokens++;
                if (bad_tokens <= MAX_REPORTS)
                    $display("%0t: unexpected token kind %0d start %0d len %0d line %0d",
                             $realtime, got_kind, got_start, got_length, got_line);
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (got_kind !== want.kind || got_start !== want.start
                    || got_length !== want.length || got_line !== want.line
                    || m_axis_tuser[3] !== want.unterm || m_axis_tlast !== want.last)
                begin
                    bad_tokens++;
                    if (bad_tokens <= MAX_REPORTS)
                    begin
                        $display("%0t: token mismatch exp kind %0d start %0d len %0d line %0d cut %0b last %0b",
                                 $realtime, want.kind, want.start, want.length, want.line,
                                 want.unterm, want.last);
                        $display("%0t:                got kind %0d start %0d len %0d line %0d cut %0b last %0b",
                                 $realtime, got_kind, got_start, got_length, got_line,
                                 m_axis_tuser[3], m_axis_tlast);
                    end
                end
            end
        end
    end

    // receiver back-pressure, switching between a few patterns
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(32, 200);
        end
        stall_left--;
        case (stall_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (cycle_count % 5 == 0);
            default: m_axis_tready <= (cycle_count % 8 != 7);
        endcase
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_item(input logic mode, input logic [7:0] data);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        predict_tokens(mode, data);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_item(mts_pkg::MODE_DATA, text[i]);
    endtask

    task automatic send_end();
        // the data byte of an end request is ignored, so it carries noise
        send_item(mts_pkg::MODE_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_all_tokens();
        s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return mts_pkg::CH_SPACE;
            1:       return mts_pkg::CH_TAB;
            2:       return mts_pkg::CH_CR;
            default: return mts_pkg::CH_LF;
        endcase
    endfunction

    task automatic send_name();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
            send_item(mts_pkg::MODE_DATA, 8'($urandom_range(8'h61, 8'h7A)));
    endtask

    task automatic send_document();
        int pieces;
        int n;
        pieces = $urandom_range(1, 8);
        repeat (pieces)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_item(mts_pkg::MODE_DATA, pick_blank());
                end
                1, 2:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                        send_item(mts_pkg::MODE_DATA, ($urandom_range(0, 3) != 0)
                                  ? 8'($urandom_range(8'h41, 8'h7A))
                                  : 8'($urandom_range(0, 255)));
                end
                3, 4:
                begin
                    send_item(mts_pkg::MODE_DATA, mts_pkg::CH_LT);
                    if ($urandom_range(0, 3) == 0) send_item(mts_pkg::MODE_DATA, pick_blank());
                    send_name();
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_item(mts_pkg::MODE_DATA, mts_pkg::CH_SPACE);
                        send_name();
                    end
                    send_item(mts_pkg::MODE_DATA, mts_pkg::CH_GT);
                end
                5:
                begin
                    send_text("</");
                    if ($urandom_range(0, 3) == 0) send_item(mts_pkg::MODE_DATA, pick_blank());
                    send_name();
                    send_item(mts_pkg::MODE_DATA, mts_pkg::CH_GT);
                end
                6:
                begin
                    send_item(mts_pkg::MODE_DATA, mts_pkg::CH_LT);
                    send_name();
                    if ($urandom_range(0, 1) == 0)
                        send_item(mts_pkg::MODE_DATA, mts_pkg::CH_SPACE);
                    send_text("/>");
                end
                7:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_text("<?");
                        send_name();
                        send_text("?>");
                    end
                    else
                    begin
                        send_text("<!");
                        send_name();
                        send_item(mts_pkg::MODE_DATA, mts_pkg::CH_GT);
                    end
                end
                8:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_item(mts_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
                end
                default:
                begin
                    // tag cut off by the end of the document
                    send_item(mts_pkg::MODE_DATA, mts_pkg::CH_LT);
                    case ($urandom_range(0, 3))
                        0: ;
                        1: send_item(mts_pkg::MODE_DATA, mts_pkg::CH_SLASH);
                        2: send_item(mts_pkg::MODE_DATA, mts_pkg::CH_QUEST);
                        default: send_name();
                    endcase
                    if ($urandom_range(0, 1) == 0) send_name();
                    send_end();
                    return;
                end
            endcase
        end
        send_end();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_end();
        // self-closing, content, ignored tags, spaced close, '<>' cut off with '>' as its name
        send_text("< a/>t<?><!></ b><>");
        send_end();
        send_item(mts_pkg::MODE_DATA, 8'h00);
        send_item(mts_pkg::MODE_DATA, 8'hFF);
        send_end();
        send_text("</");
        send_end();
        send_text("<");
        send_end();
        wait_all_tokens();
    endtask

    task automatic test_random();
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            send_document();
            if ($urandom_range(0, 19) == 0)
                wait_all_tokens();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = mts_pkg::MODE_DATA;
        m_axis_tready = 1'b0;
        bad_tokens    = 0;
        items_sent    = 0;
        cycle_count   = 0;
        burst_left    = 0;
        gap_left      = 0;
        stall_style   = 0;
        stall_left    = 0;
        clear_scan_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        wait_all_tokens();

        if (bad_tokens == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/mts_pkg.sv
src/mts_out_fifo.sv
src/mts_scan_core.sv
src/markup_token_scanner.sv
test/tb.sv
